### rtl/core/fem_pkg.sv
// shared types and constants for the free extent map
package fem_pkg;
	localparam int MAX_EXTENTS = 256;
	localparam int IDX_W = $clog2(MAX_EXTENTS);
	localparam int CNT_W = IDX_W + 1;

	localparam logic [2:0] K_FREE   = 3'd0;
	localparam logic [2:0] K_ALLOC  = 3'd1;
	localparam logic [2:0] K_WITHIN = 3'd2;
	localparam logic [2:0] K_FIND   = 3'd3;
	localparam logic [2:0] K_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] block_offset;
		logic [31:0] block_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] extent_start;
		logic [31:0] extent_length;
	} rsp_t;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] l;
	} ext_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		ext_t             wdata;
		logic [IDX_W-1:0] raddr;
	} mem_ctl_t;
endpackage

### rtl/core/fem_ram.sv
// extent ram with one write port and one registered read port
module fem_ram import fem_pkg::*; (
	input  logic     clk,
	input  mem_ctl_t ctl,
	output ext_t     rdata
);
	ext_t mem [MAX_EXTENTS];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata <= mem[ctl.raddr];
	end
endmodule

### rtl/core/fem_ctrl.sv
// sequencer: scan, shift and update of the sorted extent table
module fem_ctrl import fem_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  req_t     req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rsp_t     rsp,
	output mem_ctl_t ctl,
	input  ext_t     rdata
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_WAIT  = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_INS   = 4'd4;
	localparam logic [3:0] S_INSW  = 4'd5;
	localparam logic [3:0] S_DEL   = 4'd6;
	localparam logic [3:0] S_DELW  = 4'd7;
	localparam logic [3:0] S_RESP  = 4'd8;
	localparam logic [3:0] S_FIND  = 4'd9;
	localparam logic [3:0] S_FINDW = 4'd10;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;      // scan pointer
	logic [CNT_W-1:0] ptr_q;      // shift pointer
	logic [CNT_W-1:0] stop_q;
	req_t             req_q;
	ext_t             prev_q;
	ext_t             cur_q;
	logic             have_prev_q;
	logic             have_cur_q;
	logic [CNT_W-1:0] i_q;        // first index with start >= key
	ext_t             ins_q;      // entry written at shift end
	logic [CNT_W-1:0] ins_at_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [32:0] key;
	logic [32:0] rend;
	logic [32:0] pend;
	logic [32:0] cend;
	assign key  = (req_q.kind == K_WITHIN) ? {1'b0, req_q.block_offset} + 33'd1
	                                       : {1'b0, req_q.block_offset};
	assign rend = {1'b0, req_q.block_offset} + {1'b0, req_q.block_count};
	assign pend = {1'b0, prev_q.s} + {1'b0, prev_q.l};
	assign cend = {1'b0, cur_q.s} + {1'b0, cur_q.l};

	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		ctl = '0;
		ctl.raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_INS: begin
				ctl.raddr = ptr_q[IDX_W-1:0] - 1'b1;
			end
			S_INSW: begin
				ctl.we = 1'b1;
				ctl.waddr = ptr_q[IDX_W-1:0];
				ctl.wdata = rdata;
				ctl.raddr = ptr_q[IDX_W-1:0] - 2'd2;
			end
			S_DEL: begin
				ctl.raddr = ptr_q[IDX_W-1:0] + 1'b1;
			end
			S_DELW: begin
				ctl.we = 1'b1;
				ctl.waddr = ptr_q[IDX_W-1:0];
				ctl.wdata = rdata;
				ctl.raddr = ptr_q[IDX_W-1:0] + 2'd2;
			end
			S_RESP: begin
				ctl.we = (ins_at_q != '1);
				ctl.waddr = ins_at_q[IDX_W-1:0];
				ctl.wdata = ins_q;
			end
			default: begin
			end
		endcase
	end

	task automatic finish(input logic [1:0] st, input ext_t e);
		rsp_q <= '{status: st, extent_start: e.s, extent_length: e.l};
		rsp_valid_q <= 1'b1;
		state_q <= S_IDLE;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						req_q <= req;
						idx_q <= '0;
						have_prev_q <= 1'b0;
						ins_at_q <= '1;
						if (req.kind == K_CLEAR) begin
							cnt_q <= '0;
							finish(ST_OK, '0);
						end else if (req.kind > K_CLEAR ||
						             (req.kind != K_FIND && req.block_count == '0)) begin
							finish(ST_FAIL, '0);
						end else if (req.kind == K_FIND) begin
							state_q <= S_FIND;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_FIND, S_SCAN: begin
					if (idx_q == cnt_q) begin
						have_cur_q <= 1'b0;
						if (state_q == S_FIND) begin
							finish(ST_FAIL, '0);
						end else begin
							i_q <= idx_q;
							state_q <= S_DEC;
						end
					end else begin
						state_q <= (state_q == S_FIND) ? S_FINDW : S_WAIT;
					end
				end
				S_FINDW: begin
					if ({1'b0, rdata.s} >= key && rdata.l >= req_q.block_count) begin
						finish(ST_OK, rdata);
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_FIND;
					end
				end
				S_WAIT: begin
					if ({1'b0, rdata.s} >= key) begin
						cur_q <= rdata;
						have_cur_q <= 1'b1;
						i_q <= idx_q;
						state_q <= S_DEC;
					end else begin
						prev_q <= rdata;
						have_prev_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_DEC: begin
					unique case (req_q.kind)
						K_FREE: begin
							if (rend > 33'hFFFF_FFFF ||
							    (have_cur_q && {1'b0, cur_q.s} < rend) ||
							    (have_prev_q && pend > {1'b0, req_q.block_offset})) begin
								finish(ST_FAIL, '0);
							end else if (have_prev_q && pend == {1'b0, req_q.block_offset}
							             && have_cur_q && {1'b0, cur_q.s} == rend) begin
								ins_q <= '{s: prev_q.s, l: 32'(cend - {1'b0, prev_q.s})};
								ins_at_q <= i_q - 1'b1;
								ptr_q <= i_q;
								stop_q <= cnt_q - 1'b1;
								cnt_q <= cnt_q - 1'b1;
								state_q <= S_DEL;
							end else if (have_prev_q && pend == {1'b0, req_q.block_offset}) begin
								ins_q <= '{s: prev_q.s, l: prev_q.l + req_q.block_count};
								ins_at_q <= i_q - 1'b1;
								state_q <= S_RESP;
							end else if (have_cur_q && {1'b0, cur_q.s} == rend) begin
								ins_q <= '{s: req_q.block_offset,
								           l: cur_q.l + req_q.block_count};
								ins_at_q <= i_q;
								state_q <= S_RESP;
							end else if (cnt_q == CNT_W'(MAX_EXTENTS)) begin
								finish(ST_FULL, '0);
							end else begin
								ins_q <= '{s: req_q.block_offset, l: req_q.block_count};
								ins_at_q <= i_q;
								ptr_q <= cnt_q;
								stop_q <= i_q;
								cnt_q <= cnt_q + 1'b1;
								state_q <= S_INS;
							end
						end
						K_ALLOC: begin
							if (!have_cur_q || cur_q.s != req_q.block_offset ||
							    cur_q.l < req_q.block_count) begin
								finish(ST_FAIL, '0);
							end else if (cur_q.l == req_q.block_count) begin
								ptr_q <= i_q;
								stop_q <= cnt_q - 1'b1;
								cnt_q <= cnt_q - 1'b1;
								state_q <= S_DEL;
							end else begin
								ins_q <= '{s: cur_q.s + req_q.block_count,
								           l: cur_q.l - req_q.block_count};
								ins_at_q <= i_q;
								state_q <= S_RESP;
							end
						end
						default: begin
							// allocate within the entry before i
							if (!have_prev_q || rend > pend) begin
								finish(ST_FAIL, '0);
							end else if (req_q.block_offset == prev_q.s) begin
								if (prev_q.l == req_q.block_count) begin
									ptr_q <= i_q - 1'b1;
									stop_q <= cnt_q - 1'b1;
									cnt_q <= cnt_q - 1'b1;
									state_q <= S_DEL;
								end else begin
									ins_q <= '{s: prev_q.s + req_q.block_count,
									           l: prev_q.l - req_q.block_count};
									ins_at_q <= i_q - 1'b1;
									state_q <= S_RESP;
								end
							end else if (pend != rend) begin
								if (cnt_q == CNT_W'(MAX_EXTENTS)) begin
									finish(ST_FULL, '0);
								end else begin
									// shrink head now, tail goes in at i
									prev_q.l <= req_q.block_offset - prev_q.s;
									ins_q <= '{s: rend[31:0], l: 32'(pend - rend)};
									ins_at_q <= i_q;
									ptr_q <= cnt_q;
									stop_q <= i_q;
									cnt_q <= cnt_q + 1'b1;
									state_q <= S_INS;
								end
							end else begin
								ins_q <= '{s: prev_q.s, l: req_q.block_offset - prev_q.s};
								ins_at_q <= i_q - 1'b1;
								state_q <= S_RESP;
							end
						end
					endcase
				end
				S_INS: begin
					state_q <= (ptr_q == stop_q) ? S_RESP : S_INSW;
				end
				S_INSW: begin
					ptr_q <= ptr_q - 1'b1;
					state_q <= (ptr_q - 1'b1 == stop_q) ? S_RESP : S_INSW;
				end
				S_DEL: begin
					state_q <= (ptr_q == stop_q) ? S_RESP : S_DELW;
				end
				S_DELW: begin
					ptr_q <= ptr_q + 1'b1;
					state_q <= (ptr_q + 1'b1 == stop_q) ? S_RESP : S_DELW;
				end
				S_RESP: begin
					if (req_q.kind == K_FREE) begin
						finish(ST_OK, ins_q);
					end else if (req_q.kind == K_WITHIN && req_q.block_offset != prev_q.s
					             && pend != rend && ins_at_q == i_q) begin
						// split: write shrunken head too
						ins_q <= prev_q;
						ins_at_q <= i_q - 1'b1;
						req_q.kind <= K_ALLOC;
					end else begin
						finish(ST_OK, '0);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_EXTENTS)) else $error("count overflow");
	a_busy_nrdy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !req_ready) else $error("ready while busy");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> rsp_valid_q && $stable(rsp_q))
		else $error("result dropped");
`endif
endmodule

### rtl/core/free_extent_map.sv
// top level of the free extent map
// Keeps free extents (start, length) sorted by start in one on-chip ram.
// Input channel req_valid/req_ready carries an item {kind, block_offset,
// block_count}; the output channel rsp_valid/rsp_ready carries one item
// {status, extent_start, extent_length} for every input item.
// One item is in flight at a time. An item scans the table entry by entry,
// decides, shifts entries on insert or delete and then writes back; find
// only scans. Clear and invalid requests answer without a scan. The ram
// has one write port and one read port, one read and one write a cycle.
// Reset empties the table at once; ram contents need no clearing.
// A stalled receiver holds the result and the block accepts no new item
// until the result is taken.
module free_extent_map import fem_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);
	mem_ctl_t ctl;
	ext_t     rdata;

	fem_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.ctl(ctl), .rdata(rdata)
	);

	fem_ram u_ram (.clk(clk), .ctl(ctl), .rdata(rdata));
endmodule

### verif/free_extent_map_tb.sv
// self-checking testbench for the free extent map: queue-fed driver, monitor, local table model
module free_extent_map_tb;
	import fem_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	free_extent_map uut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the table
	logic [31:0] tbl_s[MAX_EXTENTS];
	logic [31:0] tbl_l[MAX_EXTENTS];
	int unsigned tbl_n = 0;

	req_t pending_items[$];
	rsp_t expected_rsps[$];
	int mismatches = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	bit hold_long = 1'b0;
	int unsigned cycles = 0;
	localparam int unsigned CYCLE_LIMIT = 4000000;

	function automatic int unsigned first_ge(logic [32:0] key);
		int unsigned i;
		i = 0;
		while (i < tbl_n && {1'b0, tbl_s[i]} < key) i++;
		return i;
	endfunction

	function automatic void tbl_drop(int unsigned i);
		for (int unsigned j = i; j + 1 < tbl_n; j++) begin
			tbl_s[j] = tbl_s[j+1];
			tbl_l[j] = tbl_l[j+1];
		end
		tbl_n--;
	endfunction

	function automatic void tbl_put(int unsigned i, logic [31:0] s, logic [31:0] l);
		for (int j = int'(tbl_n); j > int'(i); j--) begin
			tbl_s[j] = tbl_s[j-1];
			tbl_l[j] = tbl_l[j-1];
		end
		tbl_s[i] = s;
		tbl_l[i] = l;
		tbl_n++;
	endfunction

	function automatic void take_head(int unsigned i, logic [31:0] c);
		if (tbl_l[i] == c) tbl_drop(i);
		else begin
			tbl_s[i] += c;
			tbl_l[i] -= c;
		end
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		logic [32:0] fin, pend, xend;
		int unsigned i, e, n;
		bit mp, mn;
		o = '{status: ST_FAIL, extent_start: '0, extent_length: '0};
		fin = {1'b0, r.block_offset} + r.block_count;
		n = tbl_n;
		case (r.kind)
			K_FREE: begin
				if (r.block_count != 0 && fin <= 33'hFFFFFFFF) begin
					i = first_ge({1'b0, r.block_offset});
					pend = (i > 0) ? {1'b0, tbl_s[i-1]} + tbl_l[i-1] : '0;
					if (!(i < n && {1'b0, tbl_s[i]} < fin) &&
					    !(i > 0 && pend > {1'b0, r.block_offset})) begin
						mn = (i < n && {1'b0, tbl_s[i]} == fin);
						mp = (i > 0 && pend == {1'b0, r.block_offset});
						e = i;
						if (mp && mn) begin
							tbl_l[i-1] += r.block_count + tbl_l[i];
							tbl_drop(i);
							e = i - 1;
						end else if (mp) begin
							tbl_l[i-1] += r.block_count;
							e = i - 1;
						end else if (mn) begin
							tbl_s[i] = r.block_offset;
							tbl_l[i] += r.block_count;
						end else if (n >= MAX_EXTENTS) begin
							o.status = ST_FULL;
							return o;
						end else tbl_put(i, r.block_offset, r.block_count);
						o = '{status: ST_OK, extent_start: tbl_s[e], extent_length: tbl_l[e]};
					end
				end
			end
			K_ALLOC: begin
				if (r.block_count != 0) begin
					i = first_ge({1'b0, r.block_offset});
					if (i < n && tbl_s[i] == r.block_offset && tbl_l[i] >= r.block_count) begin
						take_head(i, r.block_count);
						o.status = ST_OK;
					end
				end
			end
			K_WITHIN: begin
				if (r.block_count != 0) begin
					i = first_ge({1'b0, r.block_offset} + 33'd1);
					if (i != 0) begin
						e = i - 1;
						xend = {1'b0, tbl_s[e]} + tbl_l[e];
						if (fin <= xend) begin
							if (r.block_offset == tbl_s[e]) begin
								take_head(e, r.block_count);
								o.status = ST_OK;
							end else if (xend != fin && n >= MAX_EXTENTS) begin
								o.status = ST_FULL;
							end else begin
								if (xend != fin) tbl_put(e + 1, fin[31:0], 32'(xend - fin));
								tbl_l[e] = r.block_offset - tbl_s[e];
								o.status = ST_OK;
							end
						end
					end
				end
			end
			K_FIND: begin
				for (i = first_ge({1'b0, r.block_offset}); i < n; i++) begin
					if (tbl_l[i] >= r.block_count) begin
						o = '{status: ST_OK, extent_start: tbl_s[i], extent_length: tbl_l[i]};
						break;
					end
				end
			end
			K_CLEAR: begin
				tbl_n = 0;
				o.status = ST_OK;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic int unsigned rand_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	// driver
	int unsigned send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(apply_request(req));
				req_valid <= 1'b0;
				send_gap = ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) send_gap--;
				else if (pending_items.size() > 0) begin
					req <= pending_items.pop_front();
					req_valid <= 1'b1;
				end
			end
		end
	end

	// long receiver stall
	int unsigned hold_cnt = 0;
	always @(posedge clk) begin
		if (arst_n && hold_req && !hold_done) begin
			if (hold_cnt >= 3000) begin
				hold_long <= 1'b0;
				hold_done = 1'b1;
			end else begin
				hold_long <= 1'b1;
				hold_cnt++;
			end
		end
	end

	// monitor
	int unsigned recv_gap = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected item %p", rsp);
				end else begin
					rsp_t x;
					x = expected_rsps.pop_front();
					if (x.status !== rsp.status || x.extent_start !== rsp.extent_start ||
					    x.extent_length !== rsp.extent_length) begin
						mismatches++;
						if (mismatches <= 10) $display("expected %p got %p", x, rsp);
					end
				end
				recv_gap = ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
			end
			if (hold_long) begin
				rsp_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_ready <= 1'b0;
			end else rsp_ready <= 1'b1;
		end
	end

	function automatic void add_item(logic [2:0] k, logic [31:0] o, logic [31:0] c);
		pending_items.push_back('{kind: k, block_offset: o, block_count: c});
	endfunction

	// mostly small offsets in a window so extents interact
	function automatic logic [31:0] pick_off(logic [31:0] base);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFFFFFF - $urandom_range(0, 8);
			default: return base + $urandom_range(0, 600);
		endcase
	endfunction

	function automatic logic [31:0] pick_cnt();
		case ($urandom_range(0, 11))
			0: return 0;
			1: return $urandom();
			2: return 32'hFFFFFFFF;
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	initial begin
		logic [31:0] base;
		int unsigned k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed
		add_item(K_FREE, 32'd100, 32'd0);
		add_item(K_FREE, 32'hFFFFFFF0, 32'h10);
		add_item(K_FREE, 32'hFFFFFFF0, 32'h0F);
		add_item(K_FREE, 32'd0, 32'd10);
		add_item(K_FREE, 32'd20, 32'd10);
		add_item(K_FREE, 32'd10, 32'd10);
		add_item(K_FREE, 32'd5, 32'd3);
		add_item(K_FREE, 32'd40, 32'd5);
		add_item(K_FREE, 32'd35, 32'd5);
		add_item(K_ALLOC, 32'd0, 32'd0);
		add_item(K_ALLOC, 32'd1, 32'd1);
		add_item(K_ALLOC, 32'd0, 32'd4);
		add_item(K_ALLOC, 32'd35, 32'd10);
		add_item(K_WITHIN, 32'd10, 32'd0);
		add_item(K_WITHIN, 32'd10, 32'd5);
		add_item(K_WITHIN, 32'd28, 32'd5);
		add_item(K_WITHIN, 32'd4, 32'd6);
		add_item(K_FIND, 32'd0, 32'd5);
		add_item(K_FIND, 32'd0, 32'hFFFFFFFF);
		add_item(K_FIND, 32'hFFFFFFFF, 32'd0);
		add_item(3'd5, 32'd0, 32'd1);
		add_item(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_item(K_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_item(K_FIND, 32'd0, 32'd0);
		// fill the table to full, then test full cases
		for (int unsigned j = 0; j < MAX_EXTENTS; j++) add_item(K_FREE, 32'd1000 + 4 * j, 32'd2);
		add_item(K_FREE, 32'd5000, 32'd1);
		add_item(K_WITHIN, 32'd1000, 32'd1);
		add_item(K_WITHIN, 32'd1004 + 0, 32'd2);
		add_item(K_FREE, 32'd1002, 32'd1);
		add_item(K_FREE, 32'd1000, 32'd1);
		add_item(K_FREE, 32'd1002, 32'd2);
		add_item(K_CLEAR, 32'd0, 32'd0);
		// random
		base = 0;
		for (int unsigned j = 0; j < 700; j++) begin
			if (j % 100 == 0) base = ($urandom_range(0, 3) == 0) ? $urandom() : 0;
			k = $urandom_range(0, 99);
			if (k < 45) add_item(K_FREE, pick_off(base), pick_cnt());
			else if (k < 60) add_item(K_ALLOC, pick_off(base), pick_cnt());
			else if (k < 75) add_item(K_WITHIN, pick_off(base), pick_cnt());
			else if (k < 95) add_item(K_FIND, pick_off(base), pick_cnt());
			else if (k < 97) add_item(K_CLEAR, $urandom(), $urandom());
			else add_item(3'($urandom_range(5, 7)), $urandom(), $urandom());
		end
		wait (pending_items.size() < 900);
		hold_req = 1'b1;
		wait (pending_items.size() == 0 && !req_valid);
		wait (expected_rsps.size() == 0);
		repeat (1000) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### sim.f
rtl/core/fem_pkg.sv
rtl/core/fem_ram.sv
rtl/core/fem_ctrl.sv
rtl/core/free_extent_map.sv
verif/free_extent_map_tb.sv
